@@ sv/pl_pkg.sv @@
// ----------------------------------------------------------------------------
// pl_pkg
// Shared types and codes for the positional list engine: request and status
// codes, default sizes and the per-cell write control.
// ----------------------------------------------------------------------------
package pl_pkg;

  // default sizes
  localparam int CAPACITY_DEF  = 64;
  localparam int ITEM_BITS_DEF = 32;

  // leaves per first-level group of the read tree
  localparam int GROUP = 8;

  // request codes
  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SWAP   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd3;

  // status codes
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  // write strobes broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
    logic swp;
  } ctrl_t;

endpackage

@@ sv/pl_cell.sv @@
// ----------------------------------------------------------------------------
// pl_cell
// One list slot. Holds the entry at its position, takes its neighbor's word
// on insert or remove, and offers its word to the read trees when addressed.
// ----------------------------------------------------------------------------
module pl_cell #(
  parameter int IDX       = 0,
  parameter int CMP_W     = 7,
  parameter int ITEM_BITS = 32
) (
  input  logic                 clk,
  input  pl_pkg::ctrl_t        ctrl,
  input  logic [CMP_W-1:0]     pa,
  input  logic [CMP_W-1:0]     pb,
  input  logic [CMP_W-1:0]     cnt,
  input  logic [ITEM_BITS-1:0] item_in,
  input  logic [ITEM_BITS-1:0] lower_d,
  input  logic [ITEM_BITS-1:0] upper_d,
  input  logic [ITEM_BITS-1:0] swap_a,
  input  logic [ITEM_BITS-1:0] swap_b,
  output logic [ITEM_BITS-1:0] d_o,
  output logic [ITEM_BITS-1:0] rd_a_o,
  output logic [ITEM_BITS-1:0] rd_b_o
);
  import pl_pkg::*;

  localparam logic [CMP_W-1:0] POS = CMP_W'(IDX);

  logic [ITEM_BITS-1:0] d_r;
  logic [ITEM_BITS-1:0] d_nxt;

  // next entry for this slot
  always_comb begin
    d_nxt = d_r;
    if (ctrl.ins) begin
      if (POS > pa && POS <= cnt) begin
        d_nxt = lower_d;
      end else if (POS == pa) begin
        d_nxt = item_in;
      end
    end else if (ctrl.rem) begin
      if (POS >= pa && (POS + CMP_W'(1)) < cnt) begin
        d_nxt = upper_d;
      end
    end else if (ctrl.swp) begin
      if (POS == pa) begin
        d_nxt = swap_b;
      end else if (POS == pb) begin
        d_nxt = swap_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  // masked read taps, only the addressed slot shows its word
  assign d_o    = d_r;
  assign rd_a_o = (POS == pa) ? d_r : '0;
  assign rd_b_o = (POS == pb) ? d_r : '0;

endmodule

@@ sv/pl_rdtree.sv @@
// ----------------------------------------------------------------------------
// pl_rdtree
// Two-level registered OR tree over the masked cell taps. At most one leaf is
// nonzero, so the OR yields the addressed entry from the group registers and then the output register.
// ----------------------------------------------------------------------------
module pl_rdtree #(
  parameter int N = 64,
  parameter int W = 32
) (
  input  logic         clk,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] dout
);
  import pl_pkg::*;

  localparam int NGRP = (N + GROUP - 1) / GROUP;

  logic [W-1:0] grp_nxt [NGRP];
  logic [W-1:0] grp_r   [NGRP];
  logic [W-1:0] dout_nxt;
  logic [W-1:0] dout_r;

  // first level, one OR per group of cells
  always_comb begin
    for (int j = 0; j < NGRP; j++) begin
      grp_nxt[j] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (j * GROUP + k < N) begin
          grp_nxt[j] = grp_nxt[j] | leaf_i[j * GROUP + k];
        end
      end
    end
  end

  // second level across the groups
  always_comb begin
    dout_nxt = '0;
    for (int j = 0; j < NGRP; j++) begin
      dout_nxt = dout_nxt | grp_r[j];
    end
  end

  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    dout_r <= dout_nxt;
  end

  assign dout = dout_r;

endmodule

@@ sv/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of fixed capacity addressed by position: insert, remove, swap
// and get, one result per request carrying the count after it.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid/in_ready    in_req_type, in_pos_a, in_pos_b, in_item_in
//  out       out_valid/out_ready  out_item_out, out_status, out_count
//
//  Each item passes through accept in S_IDLE, the registered read trees that
//  fetch the addressed entries in S_RD1 and S_RD2, and S_EXEC, in which every
//  cell shifts or writes at once and the result is registered.
//  A stalled result holds the execute cycle until the output register frees.
//  Reset clears the count and the handshake state; cell contents are left
//  as they are and only written positions are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY  = pl_pkg::CAPACITY_DEF,
  parameter int ITEM_BITS = pl_pkg::ITEM_BITS_DEF,
  parameter int POS_W     = $clog2(CAPACITY),
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [pl_pkg::REQ_W-1:0] in_req_type,
  input  logic [POS_W-1:0]         in_pos_a,
  input  logic [POS_W-1:0]         in_pos_b,
  input  logic [ITEM_BITS-1:0]     in_item_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ITEM_BITS-1:0]     out_item_out,
  output logic [pl_pkg::ST_W-1:0]  out_status,
  output logic [CNT_W-1:0]         out_count
);
  import pl_pkg::*;

  localparam int CMP_W = POS_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [REQ_W-1:0]     req_type_r;
  logic [POS_W-1:0]     req_pa_r, req_pb_r;
  logic [ITEM_BITS-1:0] req_item_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                 out_valid_r;
  logic [ITEM_BITS-1:0] out_item_r, out_item_nxt;
  logic [ST_W-1:0]      out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_count_r;

  logic [CMP_W-1:0]     pa_x, pb_x, cnt_x;
  logic                 fire;
  logic                 op_ins, op_rem, op_swp;
  ctrl_t                ctrl;

  logic [ITEM_BITS-1:0] cell_d    [CAPACITY];
  logic [ITEM_BITS-1:0] cell_rd_a [CAPACITY];
  logic [ITEM_BITS-1:0] cell_rd_b [CAPACITY];
  logic [ITEM_BITS-1:0] rd_a, rd_b;

  assign pa_x  = {1'b0, req_pa_r};
  assign pb_x  = {1'b0, req_pb_r};
  assign cnt_x = CMP_W'(cnt_r);

  assign in_ready = (state_r == S_IDLE);
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // row of cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0] lower, upper;
    if (i == 0) begin : g_lo0
      assign lower = req_item_r;
    end else begin : g_lo
      assign lower = cell_d[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hiN
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_d[i+1];
    end
    pl_cell #(
      .IDX       (i),
      .CMP_W     (CMP_W),
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pa      (pa_x),
      .pb      (pb_x),
      .cnt     (cnt_x),
      .item_in (req_item_r),
      .lower_d (lower),
      .upper_d (upper),
      .swap_a  (rd_a),
      .swap_b  (rd_b),
      .d_o     (cell_d[i]),
      .rd_a_o  (cell_rd_a[i]),
      .rd_b_o  (cell_rd_b[i])
    );
  end

  // read trees for the two addressed positions
  pl_rdtree #(.N(CAPACITY), .W(ITEM_BITS)) u_tree_a (
    .clk    (clk),
    .leaf_i (cell_rd_a),
    .dout   (rd_a)
  );

  pl_rdtree #(.N(CAPACITY), .W(ITEM_BITS)) u_tree_b (
    .clk    (clk),
    .leaf_i (cell_rd_b),
    .dout   (rd_b)
  );

  // request checks and result
  always_comb begin
    op_ins         = 1'b0;
    op_rem         = 1'b0;
    op_swp         = 1'b0;
    out_item_nxt   = '0;
    out_status_nxt = ST_OK;
    cnt_nxt        = cnt_r;
    case (req_type_r)
      REQ_INSERT: begin
        if (pa_x > cnt_x) begin
          out_status_nxt = ST_BADPOS;
        end else if (cnt_x == CMP_W'(CAPACITY)) begin
          out_status_nxt = ST_FULL;
        end else begin
          op_ins  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (pa_x >= cnt_x) begin
          out_status_nxt = ST_BADPOS;
        end else begin
          op_rem       = 1'b1;
          out_item_nxt = rd_a;
          cnt_nxt      = cnt_r - CNT_W'(1);
        end
      end
      REQ_SWAP: begin
        if (pa_x >= cnt_x || pb_x >= cnt_x) begin
          out_status_nxt = ST_BADPOS;
        end else begin
          op_swp = 1'b1;
        end
      end
      default: begin
        if (pa_x >= cnt_x) begin
          out_status_nxt = ST_BADPOS;
        end else begin
          out_item_nxt = rd_a;
        end
      end
    endcase
  end

  assign ctrl.ins = fire && op_ins;
  assign ctrl.rem = fire && op_rem;
  assign ctrl.swp = fire && op_swp;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_EXEC;
      S_EXEC:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_type_r <= in_req_type;
      req_pa_r   <= in_pos_a;
      req_pb_r   <= in_pos_b;
      req_item_r <= in_item_in;
    end
    if (fire) begin
      out_item_r   <= out_item_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= cnt_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_item_out = out_item_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

endmodule
